FILE: sv/fbc_pkg.sv
// Shared types and codes for the frustum box classify unit.
// Request, response and the token that travels down the plane cell chain.
// No dependencies.
package fbc_pkg;

   localparam int BOX_W  = 24;
   localparam int SUM_W  = BOX_W + 1;
   localparam int MASK_W = 8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   localparam logic [1:0] VERDICT_INSIDE   = 2'd0;
   localparam logic [1:0] VERDICT_STRADDLE = 2'd1;
   localparam logic [1:0] VERDICT_OUTSIDE  = 2'd2;

   typedef struct packed {
      logic                    command;
      logic [2:0]              plane_slot;
      logic signed [15:0]      normal_x;
      logic signed [15:0]      normal_y;
      logic signed [15:0]      normal_z;
      logic signed [31:0]      plane_offset;
      logic signed [BOX_W-1:0] box_min_x;
      logic signed [BOX_W-1:0] box_min_y;
      logic signed [BOX_W-1:0] box_min_z;
      logic signed [BOX_W-1:0] box_max_x;
      logic signed [BOX_W-1:0] box_max_y;
      logic signed [BOX_W-1:0] box_max_z;
   } fbc_req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [5:0] straddle_mask;
   } fbc_rsp_type;

   typedef struct packed {
      logic                    valid;
      logic                    command;
      logic [2:0]              plane_slot;
      logic signed [15:0]      normal_x;
      logic signed [15:0]      normal_y;
      logic signed [15:0]      normal_z;
      logic signed [31:0]      plane_offset;
      logic signed [SUM_W-1:0] sum_x;
      logic signed [SUM_W-1:0] sum_y;
      logic signed [SUM_W-1:0] sum_z;
      logic signed [SUM_W-1:0] diff_x;
      logic signed [SUM_W-1:0] diff_y;
      logic signed [SUM_W-1:0] diff_z;
      logic                    outside;
      logic [MASK_W-1:0]       mask;
   } fbc_token_type;

endpackage

FILE: sv/fbc_cell.sv
// One plane cell: holds one frustum plane and tests each passing box against it.
// Two register stages (products, then sums and compare). Depends on fbc_pkg.
module fbc_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  fbc_pkg::fbc_token_type tok_i,
   output fbc_pkg::fbc_token_type tok_o
);
   import fbc_pkg::*;

   localparam int PROD_W = 46;

   logic signed [15:0] nrm_x_ff, nrm_y_ff, nrm_z_ff;
   logic        [16:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic signed [31:0] off_ff;

   fbc_token_type      tok_a_ff, tok_a_in, tok_b_ff, tok_b_in;
   logic signed [40:0] p_x_ff, p_y_ff, p_z_ff, p_x_in, p_y_in, p_z_in;
   logic signed [41:0] q_x_ff, q_y_ff, q_z_ff, q_x_in, q_y_in, q_z_in;
   logic signed [31:0] off_a_ff;

   logic               load_hit;
   logic signed [PROD_W-1:0] s_val, e_val, s_minus_e, s_plus_e;

   function automatic logic [16:0] mag16(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = 17'(v);
      return (w < 0) ? 17'(-w) : 17'(w);
   endfunction

   assign load_hit = tok_i.valid && (tok_i.command == CMD_LOAD) &&
                     (tok_i.plane_slot == 3'(INDEX));

   // Plane storage is written as a load request passes the first stage,
   // so requests behind it see the new plane and requests ahead do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_x_ff <= '0;
         nrm_y_ff <= '0;
         nrm_z_ff <= '0;
         mag_x_ff <= '0;
         mag_y_ff <= '0;
         mag_z_ff <= '0;
         off_ff   <= '0;
      end else if (advance && load_hit) begin
         nrm_x_ff <= tok_i.normal_x;
         nrm_y_ff <= tok_i.normal_y;
         nrm_z_ff <= tok_i.normal_z;
         mag_x_ff <= mag16(tok_i.normal_x);
         mag_y_ff <= mag16(tok_i.normal_y);
         mag_z_ff <= mag16(tok_i.normal_z);
         off_ff   <= tok_i.plane_offset;
      end
   end

   always_comb begin
      tok_a_in = tok_i;
      p_x_in   = nrm_x_ff * tok_i.sum_x;
      p_y_in   = nrm_y_ff * tok_i.sum_y;
      p_z_in   = nrm_z_ff * tok_i.sum_z;
      q_x_in   = $signed({1'b0, mag_x_ff}) * tok_i.diff_x;
      q_y_in   = $signed({1'b0, mag_y_ff}) * tok_i.diff_y;
      q_z_in   = $signed({1'b0, mag_z_ff}) * tok_i.diff_z;
   end

   always_comb begin
      s_val = PROD_W'(p_x_ff) + PROD_W'(p_y_ff) + PROD_W'(p_z_ff) +
              (PROD_W'(off_a_ff) <<< 1);
      e_val = PROD_W'(q_x_ff) + PROD_W'(q_y_ff) + PROD_W'(q_z_ff);
      s_minus_e = s_val - e_val;
      s_plus_e  = s_val + e_val;
      tok_b_in  = tok_a_ff;
      if (tok_a_ff.command == CMD_TEST && !(s_minus_e > 0)) begin
         if (s_plus_e < 0) begin
            tok_b_in.outside = 1'b1;
         end else begin
            tok_b_in.mask[INDEX] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_a_ff.valid <= 1'b0;
         tok_b_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_a_ff <= tok_a_in;
         p_x_ff   <= p_x_in;
         p_y_ff   <= p_y_in;
         p_z_ff   <= p_z_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         q_z_ff   <= q_z_in;
         off_a_ff <= off_ff;
         tok_b_ff <= tok_b_in;
      end
   end

   assign tok_o = tok_b_ff;

endmodule

FILE: sv/frustum_box_classify_unit.sv
// Channel  | Direction | Payload              | Handshake
// req      | in        | fbc_req_type         | req_valid / req_ready
// rsp      | out       | fbc_rsp_type         | rsp_valid / rsp_ready
//
// One request enters per cycle while the chain is not stalled. A box test reaches
// rsp through one entry stage, two stages in each plane cell and one output register.
// A plane load gives no response. Reset clears every stored plane to zero.
// The chain stalls only when a finished test waits in the last cell and the
// output register is still held by rsp_ready low. Depends on fbc_pkg, fbc_cell.
module frustum_box_classify_unit #(
   parameter int NUM_PLANES = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fbc_pkg::fbc_req_type req,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fbc_pkg::fbc_rsp_type rsp
);
   import fbc_pkg::*;

   fbc_token_type entry_ff, entry_in;
   fbc_token_type chain [NUM_PLANES+1];
   fbc_token_type tail;
   logic          advance;
   logic          tail_test;
   logic          rsp_valid_ff, rsp_valid_in;
   fbc_rsp_type   rsp_ff, rsp_in;

   assign tail      = chain[NUM_PLANES];
   assign tail_test = tail.valid && (tail.command == CMD_TEST);
   assign advance   = !(tail_test && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   always_comb begin
      entry_in.valid        = req_valid;
      entry_in.command      = req.command;
      entry_in.plane_slot   = req.plane_slot;
      entry_in.normal_x     = req.normal_x;
      entry_in.normal_y     = req.normal_y;
      entry_in.normal_z     = req.normal_z;
      entry_in.plane_offset = req.plane_offset;
      entry_in.sum_x  = SUM_W'(req.box_min_x) + SUM_W'(req.box_max_x);
      entry_in.sum_y  = SUM_W'(req.box_min_y) + SUM_W'(req.box_max_y);
      entry_in.sum_z  = SUM_W'(req.box_min_z) + SUM_W'(req.box_max_z);
      entry_in.diff_x = SUM_W'(req.box_max_x) - SUM_W'(req.box_min_x);
      entry_in.diff_y = SUM_W'(req.box_max_y) - SUM_W'(req.box_min_y);
      entry_in.diff_z = SUM_W'(req.box_max_z) - SUM_W'(req.box_min_z);
      entry_in.outside = 1'b0;
      entry_in.mask    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
      fbc_cell #(.INDEX(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (chain[i]),
         .tok_o   (chain[i+1])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (advance && tail_test) begin
         rsp_valid_in = 1'b1;
         if (tail.outside) begin
            rsp_in.verdict       = VERDICT_OUTSIDE;
            rsp_in.straddle_mask = '0;
         end else begin
            rsp_in.verdict       = (tail.mask != '0) ? VERDICT_STRADDLE : VERDICT_INSIDE;
            rsp_in.straddle_mask = tail.mask[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: sv/fbc_checker.sv
// Port-level checks for frustum_box_classify_unit, attached by bind.
// Depends on fbc_pkg.
module fbc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input fbc_pkg::fbc_rsp_type rsp
);
   import fbc_pkg::*;

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.verdict == VERDICT_INSIDE || rsp.verdict == VERDICT_STRADDLE ||
                     rsp.verdict == VERDICT_OUTSIDE))
      else $error("undefined verdict code");

   // Only an intersecting verdict may carry straddle bits.
   a_mask_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.verdict != VERDICT_STRADDLE |-> rsp.straddle_mask == 6'd0)
      else $error("straddle mask set on inside or outside verdict");

   // Requests are refused only while a response is stalled.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output stall");

endmodule

bind frustum_box_classify_unit fbc_checker u_fbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
